// ----- hw/rtl/fbrm_pkg.sv -----
package fbrm_pkg;

    localparam int BUFFER_COUNT = 3;
    localparam int IDX_W        = 2;
    localparam int HOLD_W       = 8;
    localparam int LEN_W        = 20;
    localparam int TIME_W       = 48;
    localparam int INTERVAL_W   = 32;
    localparam int PADDR_W      = 3;

    localparam logic [HOLD_W-1:0] MAX_HOLDERS = HOLD_W'(255);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET =
        INTERVAL_W'((1000 / 10) * 1000 * 80 / 100);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    localparam logic [PADDR_W-1:0] ADDR_MIN_INTERVAL = PADDR_W'(0);

    typedef enum logic [1:0] {
        FUNC_ARRIVAL = 2'd0,
        FUNC_ACQUIRE = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SOON  = 3'd1,
        ST_NO_FREE   = 3'd2,
        ST_NO_FRAME  = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_SATURATED = 3'd5
    } status_t;

endpackage

// ----- hw/rtl/frame_buffer_rotation_manager_unit.sv -----
// Frame buffer rotation manager: tracks a small ring of frame buffers, the
// latest kept frame and the number of consumers holding each buffer.
// Input stream (s_*): one operation per item, kind in s_tuser (frame arrival,
// acquire latest, release buffer), operands in s_tdata. A fourth kind code is
// taken and yields no result.
// Output stream (m_*): one result per operation, status in m_tuser, buffer
// number and stored frame length in m_tdata.
// Configuration: APB register at offset 0 holds the least interval in
// microseconds between kept frames.
// A result passes through the input register and then the result register,
// with the state update logic between them; the result register loads once
// the result side can advance. One item per cycle is sustained while m_tready
// holds; each operation reads and writes the buffer state in that single pass,
// so the next item sees the update at once.
// Reset clears both stream stages, all holder counts, stored lengths and the
// latest/last-kept marks, and loads the interval register with 80000.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item; after that s_tready drops until m_tready.
module frame_buffer_rotation_manager_unit
    import fbrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // now_us[47:0], frame_len[67:48],
                                             // release_index[69:68], zero pad
    input  logic [1:0]            s_tuser,   // func[1:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // buffer_index[1:0],
                                             // result_len[21:2], zero pad
    output logic [2:0]            m_tuser,   // status[2:0]

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // input stage
    logic                  in_valid_reg;
    logic [1:0]            in_func_reg;
    logic [TIME_W-1:0]     in_now_reg;
    logic [LEN_W-1:0]      in_len_reg;
    logic [IDX_W-1:0]      in_rel_reg;

    // result stage
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;

    // buffer state
    logic [HOLD_W-1:0]     holder_reg [BUFFER_COUNT];
    logic [HOLD_W-1:0]     holder_next [BUFFER_COUNT];
    logic [LEN_W-1:0]      length_reg [BUFFER_COUNT];
    logic [LEN_W-1:0]      length_next [BUFFER_COUNT];
    logic [IDX_W-1:0]      latest_idx_reg, latest_idx_next;
    logic                  latest_valid_reg, latest_valid_next;
    logic [TIME_W-1:0]     last_time_reg, last_time_next;
    logic                  last_valid_reg, last_valid_next;
    logic [INTERVAL_W-1:0] min_interval_reg;

    logic                  advance;
    logic                  process;
    logic [TIME_W:0]       elapsed;
    logic                  too_soon;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic [HOLD_W-1:0]     latest_count;
    logic [LEN_W-1:0]      latest_len;
    logic                  rel_ok;
    logic [HOLD_W-1:0]     rel_count;
    logic [LEN_W-1:0]      rel_len;
    logic                  cfg_write;

    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - LEN_W - IDX_W){1'b0}}, out_len_reg, out_idx_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1:2] == ADDR_MIN_INTERVAL[PADDR_W-1:2])
                       ? min_interval_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_write && paddr[PADDR_W-1:2] == ADDR_MIN_INTERVAL[PADDR_W-1:2])
        begin
            min_interval_reg <= pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= s_tuser;
            in_now_reg  <= s_tdata[TIME_W-1:0];
            in_len_reg  <= s_tdata[TIME_W +: LEN_W];
            in_rel_reg  <= s_tdata[TIME_W + LEN_W +: IDX_W];
        end
    end

    // interval check and buffer lookups
    always_comb
    begin
        elapsed  = {1'b0, in_now_reg} - {1'b0, last_time_reg};
        too_soon = last_valid_reg &&
                   (elapsed[TIME_W] ||
                    elapsed[TIME_W-1:0] < {{(TIME_W - INTERVAL_W){1'b0}}, min_interval_reg});

        free_found   = 1'b0;
        free_idx     = '0;
        latest_count = '0;
        latest_len   = '0;
        rel_ok       = 1'b0;
        rel_count    = '0;
        rel_len      = '0;
        for (int i = 0; i < BUFFER_COUNT; i++)
        begin
            if (!free_found && holder_reg[i] == '0 &&
                !(latest_valid_reg && latest_idx_reg == IDX_W'(i)))
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (latest_idx_reg == IDX_W'(i))
            begin
                latest_count = holder_reg[i];
                latest_len   = length_reg[i];
            end
            if (in_rel_reg == IDX_W'(i))
            begin
                rel_ok    = 1'b1;
                rel_count = holder_reg[i];
                rel_len   = length_reg[i];
            end
        end
    end

    always_comb
    begin
        holder_next       = holder_reg;
        length_next       = length_reg;
        latest_idx_next   = latest_idx_reg;
        latest_valid_next = latest_valid_reg;
        last_time_next    = last_time_reg;
        last_valid_next   = last_valid_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_status_next   = out_status_reg;
        out_idx_next      = out_idx_reg;
        out_len_next      = out_len_reg;

        if (process)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_idx_next    = '0;
            out_len_next    = '0;
            case (in_func_reg)
                FUNC_ARRIVAL:
                begin
                    if (too_soon)
                    begin
                        out_status_next = ST_TOO_SOON;
                    end
                    else if (!free_found)
                    begin
                        out_status_next = ST_NO_FREE;
                    end
                    else
                    begin
                        for (int i = 0; i < BUFFER_COUNT; i++)
                        begin
                            if (free_idx == IDX_W'(i))
                            begin
                                length_next[i] = in_len_reg;
                            end
                        end
                        latest_idx_next   = free_idx;
                        latest_valid_next = 1'b1;
                        last_time_next    = in_now_reg;
                        last_valid_next   = 1'b1;
                        out_idx_next      = free_idx;
                        out_len_next      = in_len_reg;
                    end
                end
                FUNC_ACQUIRE:
                begin
                    if (!latest_valid_reg)
                    begin
                        out_status_next = ST_NO_FRAME;
                    end
                    else
                    begin
                        out_idx_next = latest_idx_reg;
                        out_len_next = latest_len;
                        if (latest_count >= MAX_HOLDERS)
                        begin
                            out_status_next = ST_SATURATED;
                        end
                        for (int i = 0; i < BUFFER_COUNT; i++)
                        begin
                            if (latest_idx_reg == IDX_W'(i))
                            begin
                                holder_next[i] = (latest_count >= MAX_HOLDERS)
                                                 ? MAX_HOLDERS : latest_count + 1'b1;
                            end
                        end
                    end
                end
                FUNC_RELEASE:
                begin
                    if (!rel_ok || rel_count == '0)
                    begin
                        out_status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        for (int i = 0; i < BUFFER_COUNT; i++)
                        begin
                            if (in_rel_reg == IDX_W'(i))
                            begin
                                holder_next[i] = rel_count - 1'b1;
                            end
                        end
                        out_idx_next = in_rel_reg;
                        out_len_next = rel_len;
                    end
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            latest_idx_reg   <= '0;
            latest_valid_reg <= 1'b0;
            last_time_reg    <= '0;
            last_valid_reg   <= 1'b0;
            for (int i = 0; i < BUFFER_COUNT; i++)
            begin
                holder_reg[i] <= '0;
                length_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            latest_idx_reg   <= latest_idx_next;
            latest_valid_reg <= latest_valid_next;
            last_time_reg    <= last_time_next;
            last_valid_reg   <= last_valid_next;
            holder_reg       <= holder_next;
            length_reg       <= length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_len_reg    <= out_len_next;
    end

    a_kept_marks_agree: assert property (@(posedge clk) disable iff (!rst_n)
        latest_valid_reg == last_valid_reg)
        else $error("latest and last-kept marks disagree");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while result side free");

    a_failed_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK && m_tuser != ST_SATURATED) |-> (m_tdata == '0))
        else $error("failed operation carries buffer data");

    a_latest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        latest_valid_reg |-> (latest_idx_reg < IDX_W'(BUFFER_COUNT)))
        else $error("latest buffer out of range");

endmodule
